>>> rtl/core/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/tfd_pkg.sv
// types, constants and the length rule table of the telemetry deframer
`timescale 1ns / 1ps
package tfd_pkg;

   localparam int BUFFER_BYTES_DEF = 128;

   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] LEGACY_LEN_MIN = 8'd5;
   localparam logic [7:0] LEGACY_LEN_MAX = 8'd10;
   localparam logic [7:0] LEGACY_SPAN_MAX = 8'd24;

   localparam logic [7:0] TYPE_LEGACY = 8'd1;
   localparam logic [7:0] TYPE_SPORT_POLL = 8'd9;
   localparam logic [7:0] TYPE_TRAINER = 8'd13;
   localparam logic [7:0] TYPE_CONFIG_TELEM = 8'd16;
   localparam logic [7:0] TYPE_PROTO_LIST = 8'd17;

   localparam int EN_SCRIPT = 0;
   localparam int EN_TRAINER = 1;
   localparam int EN_PROTO = 2;
   localparam logic [2:0] ENABLE_RESET = 3'd7;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_FIRST,
      PH_TYPED,
      PH_LEGACY
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_START,
      ERR_SECOND,
      ERR_OVERFLOW
   } err_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] count;
      logic [7:0] held_type;
      logic [7:0] held_length;
   } state_type;

   typedef struct packed {
      logic       stored;
      logic [7:0] value;
      logic [7:0] index;
      logic       done;
      logic       kind;
      logic [7:0] ftype;
      logic [7:0] flen;
      logic       ok;
      err_type    err;
   } result_type;

   function automatic logic length_rule(input logic [7:0] t, input logic [7:0] len,
                                        input logic [2:0] en);
      logic ok;
      ok = 1'b0;
      unique case (t)
         8'd1:             ok = (len >= 8'd5);
         8'd2, 8'd3:       ok = (len >= 8'd4);
         8'd4:             ok = (len >= 8'd17);
         8'd5:             ok = (len >= 8'd10);
         8'd6, 8'd12:      ok = (len >= 8'd28);
         8'd7:             ok = 1'b1;
         8'd8:             ok = (len >= 8'd6);
         TYPE_SPORT_POLL:  ok = en[EN_SCRIPT];
         8'd10:            ok = (len >= 8'd8);
         8'd11:            ok = (len == 8'd6);
         TYPE_TRAINER:     ok = en[EN_TRAINER] && (len >= 8'd4);
         8'd14:            ok = (len >= 8'd14);
         8'd15:            ok = (len > 8'd6);
         TYPE_CONFIG_TELEM: ok = en[EN_SCRIPT] && (len >= 8'd21);
         TYPE_PROTO_LIST:  ok = en[EN_PROTO] && (len >= 8'd1);
         default:          ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> rtl/core/telemetry_frame_deframer_top.sv
// telemetry frame deframer top level: framing state, result register and skid stage
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   req     | in        | req_valid/req_stall | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | byte, index, frame info, error code
//   csr     | in        | csr_valid/csr_ready | csr_optional_type_enable
//
// one request per cycle unless req_stall; its result is registered into rsp or skid
// the per-byte framing logic sits between the framing state and the result register
// a skid stage takes one result while rsp is stalled; req_stall rises once it is full
// synchronous reset: hunting for start byte, counters cleared, all types enabled
// csr_ready is always high; writes take effect for the next request
`timescale 1ns / 1ps
module telemetry_frame_deframer_top #(
   parameter int BUFFER_BYTES = tfd_pkg::BUFFER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_optional_type_enable,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_stored,
   output logic [7:0] rsp_byte_value,
   output logic [7:0] rsp_byte_index,
   output logic       rsp_frame_done,
   output logic       rsp_frame_kind,
   output logic [7:0] rsp_frame_type,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_length_ok,
   output logic [1:0] rsp_error_code
);

   tfd_pkg::state_type  state_ff, state_in, state_step;
   tfd_pkg::result_type step_res;
   tfd_pkg::result_type rsp_data_ff, rsp_data_in;
   tfd_pkg::result_type skid_data_ff, skid_data_in;
   logic [2:0]          enable_ff, enable_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                req_fire;
   logic                out_free;

   tfd_step #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_step (
      .cur        (state_ff),
      .rx_byte    (req_rx_byte),
      .type_enable(enable_ff),
      .nxt        (state_step),
      .res        (step_res)
   );

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_fire = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign enable_in = (csr_valid && csr_ready) ? csr_optional_type_enable : enable_ff;
   assign state_in = req_fire ? state_step : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         // skid drains first, a new request cannot arrive while it is full
         if (skid_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_fire) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = step_res;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= tfd_pkg::PH_HUNT;
         state_ff.count <= 8'd0;
         state_ff.held_type <= 8'd0;
         state_ff.held_length <= 8'd0;
         enable_ff <= tfd_pkg::ENABLE_RESET;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_stored = rsp_data_ff.stored;
   assign rsp_byte_value = rsp_data_ff.value;
   assign rsp_byte_index = rsp_data_ff.index;
   assign rsp_frame_done = rsp_data_ff.done;
   assign rsp_frame_kind = rsp_data_ff.kind;
   assign rsp_frame_type = rsp_data_ff.ftype;
   assign rsp_frame_length = rsp_data_ff.flen;
   assign rsp_length_ok = rsp_data_ff.ok;
   assign rsp_error_code = 2'(rsp_data_ff.err);

endmodule

>>> rtl/core/tfd_step.sv
// per-byte frame logic: next framing state and the result of one byte
`timescale 1ns / 1ps
module tfd_step #(
   parameter int BUFFER_BYTES = tfd_pkg::BUFFER_BYTES_DEF
) (
   input  tfd_pkg::state_type  cur,
   input  logic [7:0]          rx_byte,
   input  logic [2:0]          type_enable,
   output tfd_pkg::state_type  nxt,
   output tfd_pkg::result_type res
);

   logic       buf_full;
   logic [7:0] count_inc;
   logic [7:0] typed_len;
   logic       typed_done;
   logic       legacy_done;
   logic       legacy_start;

   assign buf_full = (cur.count >= 8'(BUFFER_BYTES));
   assign count_inc = cur.count + 8'd1;
   // the length byte counts as held as soon as it arrives
   assign typed_len = (cur.count == 8'd1) ? rx_byte : cur.held_length;
   assign typed_done = (cur.count != 8'd0) && (typed_len == cur.count - 8'd1);
   assign legacy_done = (count_inc > 8'd5) && (cur.held_length == cur.count);
   assign legacy_start = (rx_byte >= tfd_pkg::LEGACY_LEN_MIN) &&
                         (rx_byte <= tfd_pkg::LEGACY_LEN_MAX);

   always_comb begin
      nxt = cur;
      unique case (cur.phase)
         tfd_pkg::PH_HUNT: begin
            if (rx_byte == tfd_pkg::CH_M) begin
               nxt.phase = tfd_pkg::PH_FIRST;
            end
         end
         tfd_pkg::PH_FIRST: begin
            nxt.count = 8'd0;
            if (rx_byte == tfd_pkg::CH_P) begin
               nxt.phase = tfd_pkg::PH_TYPED;
            end else if (legacy_start) begin
               nxt.phase = tfd_pkg::PH_LEGACY;
               nxt.held_type = tfd_pkg::TYPE_LEGACY;
               nxt.held_length = rx_byte;
               nxt.count = 8'd1;
            end else begin
               nxt.phase = tfd_pkg::PH_HUNT;
            end
         end
         tfd_pkg::PH_TYPED: begin
            if (buf_full) begin
               nxt.phase = tfd_pkg::PH_HUNT;
            end else begin
               nxt.count = count_inc;
               if (cur.count == 8'd0) begin
                  nxt.held_type = rx_byte;
               end
               if (cur.count == 8'd1) begin
                  nxt.held_length = rx_byte;
               end
               if (typed_done) begin
                  nxt.phase = tfd_pkg::PH_HUNT;
               end
            end
         end
         tfd_pkg::PH_LEGACY: begin
            if (buf_full) begin
               nxt.count = 8'd0;
               nxt.phase = tfd_pkg::PH_HUNT;
            end else begin
               nxt.count = count_inc;
               if (legacy_done || (count_inc > tfd_pkg::LEGACY_SPAN_MAX)) begin
                  nxt.count = 8'd0;
                  nxt.phase = tfd_pkg::PH_HUNT;
               end
            end
         end
         default: nxt = cur;
      endcase
   end

   always_comb begin
      res = '0;
      res.value = rx_byte;
      res.err = tfd_pkg::ERR_NONE;
      unique case (cur.phase)
         tfd_pkg::PH_HUNT: begin
            if (rx_byte != tfd_pkg::CH_M) begin
               res.err = tfd_pkg::ERR_START;
            end
         end
         tfd_pkg::PH_FIRST: begin
            if (rx_byte != tfd_pkg::CH_P) begin
               if (legacy_start) begin
                  res.stored = 1'b1;
               end else begin
                  res.err = tfd_pkg::ERR_SECOND;
               end
            end
         end
         tfd_pkg::PH_TYPED: begin
            if (buf_full) begin
               res.err = tfd_pkg::ERR_OVERFLOW;
            end else begin
               res.stored = 1'b1;
               res.index = cur.count;
               if (typed_done) begin
                  res.done = 1'b1;
                  res.ftype = cur.held_type;
                  res.flen = typed_len;
                  res.ok = tfd_pkg::length_rule(cur.held_type, typed_len, type_enable);
               end
            end
         end
         tfd_pkg::PH_LEGACY: begin
            if (buf_full) begin
               res.err = tfd_pkg::ERR_OVERFLOW;
            end else begin
               res.stored = 1'b1;
               res.index = cur.count;
               if (legacy_done) begin
                  res.done = 1'b1;
                  res.kind = 1'b1;
                  res.ftype = tfd_pkg::TYPE_LEGACY;
                  res.flen = cur.held_length;
                  res.ok = tfd_pkg::length_rule(tfd_pkg::TYPE_LEGACY, cur.held_length,
                                                type_enable);
               end
            end
         end
         default: res.err = tfd_pkg::ERR_NONE;
      endcase
   end

endmodule

>>> rtl/core/tfd_checker.sv
// port-level checker for the telemetry deframer and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_byte_stored,
   input logic [7:0] rsp_byte_value,
   input logic [7:0] rsp_byte_index,
   input logic       rsp_frame_done,
   input logic       rsp_frame_kind,
   input logic [7:0] rsp_frame_type,
   input logic [7:0] rsp_frame_length,
   input logic       rsp_length_ok,
   input logic [1:0] rsp_error_code
);

   // a stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_byte_value) && $stable(rsp_byte_index) && $stable(rsp_error_code))

   // frame info is zero unless a frame ends
   `ASSERT_IMPLIES(a_idle_frame_info, clock, reset, rsp_valid && !rsp_frame_done, !rsp_frame_kind && rsp_frame_type == 8'd0 && rsp_frame_length == 8'd0 && !rsp_length_ok)

   // an errored byte is neither stored nor ends a frame
   `ASSERT_IMPLIES(a_error_drops, clock, reset, rsp_valid && rsp_error_code != 2'd0, !rsp_byte_stored && !rsp_frame_done && rsp_byte_index == 8'd0)

   // legacy status frames are type 1 and always pass the length rule
   `ASSERT_IMPLIES(a_legacy_frame, clock, reset, rsp_valid && rsp_frame_done && rsp_frame_kind, rsp_frame_type == 8'd1 && rsp_length_ok && rsp_frame_length >= 8'd5 && rsp_frame_length <= 8'd10)

endmodule

bind telemetry_frame_deframer_top tfd_checker u_tfd_checker (.*);
